// ----- src/rffwa_pkg.sv -----
package rffwa_pkg;

  // Ring geometry.
  localparam int RING_HUBS = 16;
  localparam int HUB_W     = 4;
  localparam int RING_W    = RING_HUBS * HUB_W;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WL_IN_USE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_ORDER = 1'b1;

  // Operation codes.
  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_CLEAR    = 1'b1;

  // Register widths and reset values.
  localparam int WL_CFG_W = 6;
  localparam int WL_IDX_W = 6;
  localparam int WL_OUT_W = 5;
  localparam int STATUS_W = 2;
  localparam logic [WL_CFG_W-1:0] WL_IN_USE_RST  = 6'd32;
  localparam logic [RING_W-1:0]   RING_ORDER_RST = 64'h48CDEFBA95673210;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_CLEARED   = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_UNION,
    S_PICK,
    S_MARK,
    S_DONE
  } state_t;

  // Result of a hub position search.
  typedef struct packed {
    logic             found;
    logic [HUB_W-1:0] pos;
  } pos_t;

  // Control of the occupancy store.
  typedef struct packed {
    logic             clr;
    logic             set;
    logic [HUB_W-1:0] ptr;
  } occ_ctl_t;

endpackage

// ----- src/rffwa_hub_lookup.sv -----
module rffwa_hub_lookup (
  input  logic [rffwa_pkg::RING_W-1:0] ring_order,
  input  logic [rffwa_pkg::HUB_W-1:0]  hub,
  output rffwa_pkg::pos_t              pos
);

  // Lowest ring position holding the hub id wins.
  always_comb begin
    pos = '0;
    for (int p = rffwa_pkg::RING_HUBS - 1; p >= 0; p--) begin
      if (ring_order[p*rffwa_pkg::HUB_W +: rffwa_pkg::HUB_W] == hub) begin
        pos.found = 1'b1;
        pos.pos   = rffwa_pkg::HUB_W'(p);
      end
    end
  end

endmodule

// ----- src/rffwa_occ_store.sv -----
module rffwa_occ_store #(
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rffwa_pkg::occ_ctl_t  ctl,
  input  logic [WIDTH-1:0]     set_mask,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] occ_r   [rffwa_pkg::RING_HUBS];
  logic [WIDTH-1:0] occ_nxt [rffwa_pkg::RING_HUBS];

  // One segment is read per cycle, at the walk pointer.
  assign rd_data = occ_r[ctl.ptr];

  // A clear empties every segment; a set marks one wavelength on one segment.
  always_comb begin
    for (int p = 0; p < rffwa_pkg::RING_HUBS; p++) begin
      occ_nxt[p] = occ_r[p];
    end
    if (ctl.clr) begin
      for (int p = 0; p < rffwa_pkg::RING_HUBS; p++) begin
        occ_nxt[p] = '0;
      end
    end else if (ctl.set) begin
      occ_nxt[ctl.ptr] = occ_r[ctl.ptr] | set_mask;
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < rffwa_pkg::RING_HUBS; p++) begin
      if (!rst_n) begin
        occ_r[p] <= '0;
      end else begin
        occ_r[p] <= occ_nxt[p];
      end
    end
  end

endmodule

// ----- src/ring_first_fit_wavelength_allocator_top.sv -----
// First-fit wavelength allocator for one unidirectional ring of sixteen hubs. An allocate
// transaction (tuser low) names a source and destination hub; the block finds both in the
// configured ring order, walks the segments from source to destination once to collect the
// busy wavelengths, picks the lowest free one below the usable count, and walks the same
// segments again to mark it busy. One segment is visited per cycle by the walk pointer of
// the single-ported occupancy store, so a granted allocation over D segments walks them
// twice and one that finds no free wavelength walks them once; a clear, a same-hub request
// or an unknown hub walks no segment and goes from lookup straight to the result hand-off.
// One transaction is in flight at a time; the result sits in an output register,
// and a result still waiting there holds the block in its hand-off state until it is taken.
module ring_first_fit_wavelength_allocator_top #(
  parameter int WL_SLOTS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,  // [3:0] source_hub, [7:4] dest_hub
  input  logic                              in_tuser,  // [0] operation
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata, // [1:0] status, [6:2] wavelength
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rffwa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rffwa_pkg::RING_W-1:0]      cfg_data
);

  localparam int CNT_W = rffwa_pkg::WL_IDX_W + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(WL_SLOTS);

  // Configuration registers.
  logic [rffwa_pkg::WL_CFG_W-1:0] wl_use_r;
  logic [rffwa_pkg::RING_W-1:0]   ring_r;

  // Sequencer state and request registers.
  rffwa_pkg::state_t              state_r, state_nxt;
  logic                           op_r, op_nxt;
  logic [rffwa_pkg::HUB_W-1:0]    src_r, src_nxt;
  logic [rffwa_pkg::HUB_W-1:0]    dst_r, dst_nxt;
  logic [rffwa_pkg::HUB_W-1:0]    ps_r, ps_nxt;
  logic [rffwa_pkg::HUB_W-1:0]    pd_r, pd_nxt;
  logic [rffwa_pkg::HUB_W-1:0]    ptr_r, ptr_nxt;
  logic [WL_SLOTS-1:0]            busy_r, busy_nxt;
  logic [rffwa_pkg::WL_IDX_W-1:0] wl_r, wl_nxt;
  rffwa_pkg::status_t             res_status_r, res_status_nxt;
  logic [rffwa_pkg::WL_OUT_W-1:0] res_wl_r, res_wl_nxt;

  // Output register.
  logic                           out_valid_r, out_valid_nxt;
  rffwa_pkg::status_t             out_status_r, out_status_nxt;
  logic [rffwa_pkg::WL_OUT_W-1:0] out_wl_r, out_wl_nxt;

  // Datapath signals.
  rffwa_pkg::pos_t                src_pos, dst_pos;
  rffwa_pkg::occ_ctl_t            occ_ctl;
  logic [WL_SLOTS-1:0]            set_mask;
  logic [WL_SLOTS-1:0]            occ_rd;
  logic [CNT_W-1:0]               wl_cnt;
  logic [WL_SLOTS-1:0]            cnt_mask;
  logic [WL_SLOTS-1:0]            free_vec;
  logic [rffwa_pkg::WL_IDX_W-1:0] first_free;
  logic [rffwa_pkg::HUB_W-1:0]    ptr_inc;

  // Hub position searches over the ring order.
  rffwa_hub_lookup u_src_lookup (
    .ring_order (ring_r),
    .hub        (src_r),
    .pos        (src_pos)
  );

  rffwa_hub_lookup u_dst_lookup (
    .ring_order (ring_r),
    .hub        (dst_r),
    .pos        (dst_pos)
  );

  // Per-segment occupancy.
  rffwa_occ_store #(
    .WIDTH (WL_SLOTS)
  ) u_occ_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (occ_ctl),
    .set_mask (set_mask),
    .rd_data  (occ_rd)
  );

  // Configuration writes are always taken; an unused index changes nothing.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_use_r <= rffwa_pkg::WL_IN_USE_RST;
      ring_r   <= rffwa_pkg::RING_ORDER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rffwa_pkg::CFG_WL_IN_USE:  wl_use_r <= cfg_data[rffwa_pkg::WL_CFG_W-1:0];
        rffwa_pkg::CFG_RING_ORDER: ring_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Usable count: zero acts as one, anything above the store width is clipped.
  always_comb begin
    wl_cnt = (wl_use_r == '0) ? CNT_W'(1) : {1'b0, wl_use_r};
    if (wl_cnt > MAX_CNT) begin
      wl_cnt = MAX_CNT;
    end
    for (int i = 0; i < WL_SLOTS; i++) begin
      cnt_mask[i] = (CNT_W'(i) < wl_cnt);
    end
  end

  // Lowest free wavelength among the usable ones.
  assign free_vec = ~busy_r & cnt_mask;

  always_comb begin
    first_free = '0;
    for (int i = WL_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        first_free = rffwa_pkg::WL_IDX_W'(i);
      end
    end
  end

  assign ptr_inc  = ptr_r + 1'b1;
  assign set_mask = WL_SLOTS'(1) << wl_r;

  // Sequencer: lookup, busy union walk, pick, mark walk, result hand-off.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    ps_nxt         = ps_r;
    pd_nxt         = pd_r;
    ptr_nxt        = ptr_r;
    busy_nxt       = busy_r;
    wl_nxt         = wl_r;
    res_status_nxt = res_status_r;
    res_wl_nxt     = res_wl_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_wl_nxt     = out_wl_r;
    in_tready      = 1'b0;
    occ_ctl        = '0;
    occ_ctl.ptr    = ptr_r;

    case (state_r)
      rffwa_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          src_nxt   = in_tdata[3:0];
          dst_nxt   = in_tdata[7:4];
          state_nxt = rffwa_pkg::S_LOOKUP;
        end
      end

      rffwa_pkg::S_LOOKUP: begin
        res_wl_nxt = '0;
        state_nxt  = rffwa_pkg::S_DONE;
        if (op_r == rffwa_pkg::OP_CLEAR) begin
          occ_ctl.clr    = 1'b1;
          res_status_nxt = rffwa_pkg::ST_CLEARED;
        end else if (!src_pos.found || !dst_pos.found) begin
          res_status_nxt = rffwa_pkg::ST_NONE_FREE;
        end else if (src_pos.pos == dst_pos.pos) begin
          res_status_nxt = rffwa_pkg::ST_GRANTED;
        end else begin
          ps_nxt    = src_pos.pos;
          pd_nxt    = dst_pos.pos;
          ptr_nxt   = src_pos.pos;
          busy_nxt  = '0;
          state_nxt = rffwa_pkg::S_UNION;
        end
      end

      rffwa_pkg::S_UNION: begin
        busy_nxt = busy_r | occ_rd;
        ptr_nxt  = ptr_inc;
        if (ptr_inc == pd_r) begin
          state_nxt = rffwa_pkg::S_PICK;
        end
      end

      rffwa_pkg::S_PICK: begin
        if (|free_vec) begin
          wl_nxt    = first_free;
          ptr_nxt   = ps_r;
          state_nxt = rffwa_pkg::S_MARK;
        end else begin
          res_status_nxt = rffwa_pkg::ST_NONE_FREE;
          res_wl_nxt     = '0;
          state_nxt      = rffwa_pkg::S_DONE;
        end
      end

      rffwa_pkg::S_MARK: begin
        occ_ctl.set = 1'b1;
        ptr_nxt     = ptr_inc;
        if (ptr_inc == pd_r) begin
          res_status_nxt = rffwa_pkg::ST_GRANTED;
          res_wl_nxt     = wl_r[rffwa_pkg::WL_OUT_W-1:0];
          state_nxt      = rffwa_pkg::S_DONE;
        end
      end

      rffwa_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_wl_nxt     = res_wl_r;
          state_nxt      = rffwa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = rffwa_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rffwa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    ps_r         <= ps_nxt;
    pd_r         <= pd_nxt;
    ptr_r        <= ptr_nxt;
    busy_r       <= busy_nxt;
    wl_r         <= wl_nxt;
    res_status_r <= res_status_nxt;
    res_wl_r     <= res_wl_nxt;
    out_status_r <= out_status_nxt;
    out_wl_r     <= out_wl_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_wl_r, out_status_r};

  // The walk pointer never stands on the destination position while walking.
  a_walk_stops_at_dest: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rffwa_pkg::S_UNION || state_r == rffwa_pkg::S_MARK) |-> ptr_r != pd_r)
    else $error("walk pointer reached destination position");

  // A wavelength being marked was free on every walked segment.
  a_mark_was_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rffwa_pkg::S_MARK |-> (occ_rd & set_mask) == '0)
    else $error("marking a wavelength that is already busy");

  // Only a grant carries a nonzero wavelength.
  a_wl_zero_unless_granted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != rffwa_pkg::ST_GRANTED) |-> out_wl_r == '0)
    else $error("nonzero wavelength without a grant");

  // A result is only produced as the sequencer leaves its hand-off state.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == rffwa_pkg::S_DONE)
    else $error("result appeared outside hand-off");

endmodule
